// ===== hdl/psd_pkg.sv =====
// Shared types for the point-to-segment distance pipeline.
// Used by the division cells, the square-root cells and the top level.
package psd_pkg;

	// Control word that travels with each item through a row of cells.
	typedef struct packed {
		logic vld;    // item present in this stage
		logic inner;  // projection fell on the segment
	} psd_ctl_t;

endpackage

// ===== hdl/psd_div_cell.sv =====
// One restoring division step: shift in a dividend bit, trial-subtract the divisor.
// Depends on psd_pkg for the control word.
module psd_div_cell #(
	parameter int RW = 33,
	parameter int LW = 35
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psd_pkg::psd_ctl_t    ctl_i,
	input  logic [RW-1:0]        div_i,
	input  logic [RW-1:0]        rem_i,
	input  logic [LW-1:0]        low_i,
	output psd_pkg::psd_ctl_t    ctl_o,
	output logic [RW-1:0]        div_o,
	output logic [RW-1:0]        rem_o,
	output logic [LW-1:0]        low_o
);

	logic [RW:0]       trial;
	logic [RW:0]       diff;
	logic              fits;
	psd_pkg::psd_ctl_t ctl_q;
	logic [RW-1:0]     div_q;
	logic [RW-1:0]     rem_q;
	logic [LW-1:0]     low_q;

	assign trial = {rem_i, low_i[LW-1]};
	assign diff  = trial - {1'b0, div_i};
	assign fits  = (trial >= {1'b0, div_i});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_i;
		end
	end

	// quotient bits enter at the bottom as dividend bits leave at the top
	always_ff @(posedge clk) begin
		div_q <= div_i;
		rem_q <= fits ? diff[RW-1:0] : trial[RW-1:0];
		low_q <= {low_i[LW-2:0], fits};
	end

	assign ctl_o = ctl_q;
	assign div_o = div_q;
	assign rem_o = rem_q;
	assign low_o = low_q;

endmodule

// ===== hdl/psd_sqrt_cell.sv =====
// One digit of a restoring integer square root: take two operand bits, settle one root bit.
// Depends on psd_pkg for the control word.
module psd_sqrt_cell #(
	parameter int NB = 18
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  psd_pkg::psd_ctl_t    ctl_i,
	input  logic [2*NB-1:0]      op_i,
	input  logic [NB-1:0]        root_i,
	input  logic [NB+1:0]        rem_i,
	output psd_pkg::psd_ctl_t    ctl_o,
	output logic [2*NB-1:0]      op_o,
	output logic [NB-1:0]        root_o,
	output logic [NB+1:0]        rem_o
);

	logic [NB+3:0]     part;
	logic [NB+3:0]     trial;
	logic [NB+3:0]     diff;
	logic              fits;
	psd_pkg::psd_ctl_t ctl_q;
	logic [2*NB-1:0]   op_q;
	logic [NB-1:0]     root_q;
	logic [NB+1:0]     rem_q;

	assign part  = {rem_i, op_i[2*NB-1 -: 2]};
	assign trial = {2'b00, root_i, 2'b01};
	assign diff  = part - trial;
	assign fits  = (part >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		op_q   <= {op_i[2*NB-3:0], 2'b00};
		root_q <= {root_i[NB-2:0], fits};
		rem_q  <= fits ? diff[NB+1:0] : part[NB+1:0];
	end

	assign ctl_o  = ctl_q;
	assign op_o   = op_q;
	assign root_o = root_q;
	assign rem_o  = rem_q;

endmodule

// ===== hdl/point_segment_distance.sv =====
// Top level of the point-to-segment distance pipeline.
// Depends on psd_pkg, psd_div_cell and psd_sqrt_cell.
//
// Usage
//   Drive segment ends A (start_x/y), B (end_x/y) and a point C (point_x/y), all signed
//   fixed point, with start high for one cycle. The transfer takes place at the edge where
//   start is high and busy is low; busy stays low, so a new item may enter every cycle.
//   Each item yields one result: done is high for exactly one cycle with distance,
//   nearest_x, nearest_y and on_interior. The receiver cannot stall; take the result then.
// Pipeline
//   A result is strobed after its transfer has passed through four set-up stages, a row
//   of 2*COORD_BITS+3 division cells that forms cross^2/|B-A|^2, a row of COORD_BITS+2
//   square-root cells and the output register. One item per cycle; the division row
//   settles one quotient bit per cell.
//   The nearest-point quotients run in two shorter rows alongside and wait in delay lines.
// Reset
//   arst_n clears every valid bit at once; items in flight are dropped and done stays low.
//   Results all use the coordinates' own Q format, so the fraction width does not enter.
module point_segment_distance #(
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	output logic                         done,
	output logic        [COORD_BITS:0]   distance,
	output logic signed [COORD_BITS-1:0] nearest_x,
	output logic signed [COORD_BITS-1:0] nearest_y,
	output logic                         on_interior
);

	localparam int C   = COORD_BITS;
	localparam int RW  = 2*C + 1;          // divisor |B-A|^2 and remainders
	localparam int LQ  = 2*C + 3;          // quotient bits of cross^2 / |B-A|^2
	localparam int NX  = C + 1;            // quotient bits of the projection offset
	localparam int NSQ = C + 2;            // root bits
	localparam int HL  = C + 2;            // split point for squaring the cross product
	localparam int W2  = 4*C + 7;          // width of the cross product squared, signed
	localparam int NSB = LQ + NSQ;         // sideband delay behind stage 4
	localparam int MX  = NSB - NX;         // wait of the offset quotients
	localparam int LAT = LQ + NSQ + 5;     // transfer to strobe, in edges

	typedef struct packed {
		logic signed [C-1:0] ax;
		logic signed [C-1:0] ay;
		logic signed [C-1:0] epx;
		logic signed [C-1:0] epy;
		logic                xneg;
		logic                yneg;
	} side_t;

	// ---------------- stage 1: differences ----------------
	logic                vld_s1;
	logic signed [C-1:0] ax_s1, ay_s1, bx_s1, by_s1;
	logic signed [C:0]   dx_s1, dy_s1, ex_s1, ey_s1, fx_s1, fy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		ax_s1 <= start_x;
		ay_s1 <= start_y;
		bx_s1 <= end_x;
		by_s1 <= end_y;
		dx_s1 <= (C+1)'(end_x) - (C+1)'(start_x);
		dy_s1 <= (C+1)'(end_y) - (C+1)'(start_y);
		ex_s1 <= (C+1)'(point_x) - (C+1)'(start_x);
		ey_s1 <= (C+1)'(point_y) - (C+1)'(start_y);
		fx_s1 <= (C+1)'(point_x) - (C+1)'(end_x);
		fy_s1 <= (C+1)'(point_y) - (C+1)'(end_y);
	end

	// ---------------- stage 2: dot, cross, squared lengths ----------------
	logic signed [2*C+1:0] p_exdx, p_eydy, p_dxdx, p_dydy, p_eydx, p_exdy;
	logic signed [2*C+1:0] p_exex, p_eyey, p_fxfx, p_fyfy;
	logic                  vld_s2;
	logic signed [C-1:0]   ax_s2, ay_s2, bx_s2, by_s2;
	logic signed [C:0]     dx_s2, dy_s2;
	logic signed [2*C+2:0] n_s2, x_s2;
	logic        [RW-1:0]  d_s2, d1_s2, d2_s2;
	logic signed [2*C+2:0] dsum, d1sum, d2sum;

	assign p_exdx = ex_s1 * dx_s1;
	assign p_eydy = ey_s1 * dy_s1;
	assign p_dxdx = dx_s1 * dx_s1;
	assign p_dydy = dy_s1 * dy_s1;
	assign p_eydx = ey_s1 * dx_s1;
	assign p_exdy = ex_s1 * dy_s1;
	assign p_exex = ex_s1 * ex_s1;
	assign p_eyey = ey_s1 * ey_s1;
	assign p_fxfx = fx_s1 * fx_s1;
	assign p_fyfy = fy_s1 * fy_s1;
	assign dsum   = (2*C+3)'(p_dxdx) + (2*C+3)'(p_dydy);
	assign d1sum  = (2*C+3)'(p_exex) + (2*C+3)'(p_eyey);
	assign d2sum  = (2*C+3)'(p_fxfx) + (2*C+3)'(p_fyfy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2 <= ax_s1;
		ay_s2 <= ay_s1;
		bx_s2 <= bx_s1;
		by_s2 <= by_s1;
		dx_s2 <= dx_s1;
		dy_s2 <= dy_s1;
		n_s2  <= (2*C+3)'(p_exdx) + (2*C+3)'(p_eydy);
		x_s2  <= (2*C+3)'(p_eydx) - (2*C+3)'(p_exdy);
		d_s2  <= dsum[RW-1:0];
		d1_s2 <= d1sum[RW-1:0];
		d2_s2 <= d2sum[RW-1:0];
	end

	// ---------------- stage 3: classify, offsets, partial squares of cross ----------------
	logic                  inner_c, near_a;
	logic signed [C:0]     xh;
	logic        [C+1:0]   xl;
	logic                  vld_s3, inner_s3;
	logic signed [C-1:0]   ax_s3, ay_s3, epx_s3, epy_s3;
	logic        [RW-1:0]  d_s3;
	logic        [LQ-1:0]  ext_s3;
	logic signed [3*C+3:0] ndx_s3, ndy_s3;
	logic signed [2*C+1:0] phh_s3;
	logic signed [2*C+3:0] phl_s3;
	logic        [2*C+3:0] pll_s3;

	assign inner_c = (d_s2 != '0) && !n_s2[2*C+2] && (n_s2 <= (2*C+3)'(d_s2));
	assign near_a  = (d1_s2 < d2_s2);        // ties go to B
	assign xh      = x_s2[2*C+2:HL];
	assign xl      = x_s2[HL-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		inner_s3 <= inner_c;
		ax_s3    <= ax_s2;
		ay_s3    <= ay_s2;
		epx_s3   <= near_a ? ax_s2 : bx_s2;
		epy_s3   <= near_a ? ay_s2 : by_s2;
		ext_s3   <= LQ'(near_a ? d1_s2 : d2_s2);
		d_s3     <= d_s2;
		ndx_s3   <= n_s2 * dx_s2;
		ndy_s3   <= n_s2 * dy_s2;
		phh_s3   <= xh * xh;
		phl_s3   <= xh * $signed({1'b0, xl});
		pll_s3   <= xl * xl;
	end

	// ---------------- stage 4: cross squared, offset magnitudes ----------------
	logic signed [W2-1:0]  x2w;
	logic        [3*C+3:0] ndx_mag, ndy_mag;
	logic                  vld_s4, inner_s4;
	logic        [W2-2:0]  x2_s4;
	logic        [RW-1:0]  d_s4;
	logic        [LQ-1:0]  ext_s4;
	logic        [3*C+2:0] mx_s4, my_s4;
	side_t                 side_s4;

	assign x2w = (W2'(phh_s3) <<< (2*HL)) + (W2'(phl_s3) <<< (HL+1))
		+ $signed(W2'(pll_s3));
	assign ndx_mag = ndx_s3[3*C+3] ? -ndx_s3 : ndx_s3;
	assign ndy_mag = ndy_s3[3*C+3] ? -ndy_s3 : ndy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		inner_s4     <= inner_s3;
		x2_s4        <= x2w[W2-2:0];
		d_s4         <= d_s3;
		ext_s4       <= ext_s3;
		mx_s4        <= ndx_mag[3*C+2:0];
		my_s4        <= ndy_mag[3*C+2:0];
		side_s4.ax   <= ax_s3;
		side_s4.ay   <= ay_s3;
		side_s4.epx  <= epx_s3;
		side_s4.epy  <= epy_s3;
		side_s4.xneg <= ndx_s3[3*C+3];
		side_s4.yneg <= ndy_s3[3*C+3];
	end

	// ---------------- rows of cells ----------------
	psd_pkg::psd_ctl_t ctl_s4;
	assign ctl_s4 = '{vld: vld_s4, inner: inner_s4};

	// cross^2 / |B-A|^2
	psd_pkg::psd_ctl_t q_ctl [LQ+1];
	logic [RW-1:0]     q_div [LQ+1];
	logic [RW-1:0]     q_rem [LQ+1];
	logic [LQ-1:0]     q_low [LQ+1];

	assign q_ctl[0] = ctl_s4;
	assign q_div[0] = d_s4;
	assign q_rem[0] = x2_s4[LQ+RW-1:LQ];
	assign q_low[0] = x2_s4[LQ-1:0];

	// projection offsets along x and y
	psd_pkg::psd_ctl_t x_ctl [NX+1];
	logic [RW-1:0]     x_div [NX+1];
	logic [RW-1:0]     x_rem [NX+1];
	logic [NX-1:0]     x_low [NX+1];
	psd_pkg::psd_ctl_t y_ctl [NX+1];
	logic [RW-1:0]     y_div [NX+1];
	logic [RW-1:0]     y_rem [NX+1];
	logic [NX-1:0]     y_low [NX+1];

	assign x_ctl[0] = ctl_s4;
	assign x_div[0] = d_s4;
	assign x_rem[0] = mx_s4[3*C+1:NX];
	assign x_low[0] = mx_s4[NX-1:0];
	assign y_ctl[0] = ctl_s4;
	assign y_div[0] = d_s4;
	assign y_rem[0] = my_s4[3*C+1:NX];
	assign y_low[0] = my_s4[NX-1:0];

	for (genvar i = 0; i < LQ; i++) begin : g_qrow
		psd_div_cell #(.RW(RW), .LW(LQ)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(q_ctl[i]), .div_i(q_div[i]), .rem_i(q_rem[i]), .low_i(q_low[i]),
			.ctl_o(q_ctl[i+1]), .div_o(q_div[i+1]), .rem_o(q_rem[i+1]), .low_o(q_low[i+1])
		);
	end

	for (genvar i = 0; i < NX; i++) begin : g_xyrow
		psd_div_cell #(.RW(RW), .LW(NX)) u_xcell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(x_ctl[i]), .div_i(x_div[i]), .rem_i(x_rem[i]), .low_i(x_low[i]),
			.ctl_o(x_ctl[i+1]), .div_o(x_div[i+1]), .rem_o(x_rem[i+1]), .low_o(x_low[i+1])
		);
		psd_div_cell #(.RW(RW), .LW(NX)) u_ycell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(y_ctl[i]), .div_i(y_div[i]), .rem_i(y_rem[i]), .low_i(y_low[i]),
			.ctl_o(y_ctl[i+1]), .div_o(y_div[i+1]), .rem_o(y_rem[i+1]), .low_o(y_low[i+1])
		);
	end

	// delay lines: sideband behind stage 4, endpoint operand, offset quotients
	side_t        side_q [NSB];
	logic [LQ-1:0] ext_q [LQ];
	logic [NX-1:0] qx_q  [MX];
	logic [NX-1:0] qy_q  [MX];

	always_ff @(posedge clk) begin
		side_q[0] <= side_s4;
		for (int i = 1; i < NSB; i++) begin
			side_q[i] <= side_q[i-1];
		end
		ext_q[0] <= ext_s4;
		for (int i = 1; i < LQ; i++) begin
			ext_q[i] <= ext_q[i-1];
		end
		qx_q[0] <= x_low[NX];
		qy_q[0] <= y_low[NX];
		for (int i = 1; i < MX; i++) begin
			qx_q[i] <= qx_q[i-1];
			qy_q[i] <= qy_q[i-1];
		end
	end

	// square root of either the interior quotient or the nearer end's squared distance
	psd_pkg::psd_ctl_t s_ctl  [NSQ+1];
	logic [2*NSQ-1:0]  s_op   [NSQ+1];
	logic [NSQ-1:0]    s_root [NSQ+1];
	logic [NSQ+1:0]    s_rem  [NSQ+1];

	assign s_ctl[0]  = q_ctl[LQ];
	assign s_op[0]   = (2*NSQ)'(q_ctl[LQ].inner ? q_low[LQ] : ext_q[LQ-1]);
	assign s_root[0] = '0;
	assign s_rem[0]  = '0;

	for (genvar i = 0; i < NSQ; i++) begin : g_srow
		psd_sqrt_cell #(.NB(NSQ)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.ctl_i(s_ctl[i]), .op_i(s_op[i]), .root_i(s_root[i]), .rem_i(s_rem[i]),
			.ctl_o(s_ctl[i+1]), .op_o(s_op[i+1]), .root_o(s_root[i+1]), .rem_o(s_rem[i+1])
		);
	end

	// ---------------- output register ----------------
	side_t               side_end;
	logic [C+1:0]        offx, offy, sumx, sumy;
	logic                done_q, inner_q;
	logic [C:0]          dist_q;
	logic signed [C-1:0] nx_q, ny_q;

	assign side_end = side_q[NSB-1];
	// restore the sign of the truncated offsets
	assign offx = side_end.xneg ? -{1'b0, qx_q[MX-1]} : {1'b0, qx_q[MX-1]};
	assign offy = side_end.yneg ? -{1'b0, qy_q[MX-1]} : {1'b0, qy_q[MX-1]};
	assign sumx = (C+2)'(side_end.ax) + offx;
	assign sumy = (C+2)'(side_end.ay) + offy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= s_ctl[NSQ].vld;
		end
	end

	always_ff @(posedge clk) begin
		inner_q <= s_ctl[NSQ].inner;
		dist_q  <= s_root[NSQ][C:0];
		nx_q    <= s_ctl[NSQ].inner ? sumx[C-1:0] : side_end.epx;
		ny_q    <= s_ctl[NSQ].inner ? sumy[C-1:0] : side_end.epy;
	end

	assign busy        = 1'b0;
	assign done        = done_q;
	assign distance    = dist_q;
	assign nearest_x   = nx_q;
	assign nearest_y   = ny_q;
	assign on_interior = inner_q;

	// ---------------- checks ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing after transfer");

	a_qrem: assert property (@(posedge clk) disable iff (!arst_n)
		(q_ctl[LQ].vld && q_ctl[LQ].inner) |-> (q_rem[LQ] < q_div[LQ]))
		else $error("division remainder not below divisor");

	a_sqrem: assert property (@(posedge clk) disable iff (!arst_n)
		s_ctl[NSQ].vld |-> (s_rem[NSQ] <= (NSQ+2)'({s_root[NSQ], 1'b0})))
		else $error("square root remainder too large");

	a_xyrow: assert property (@(posedge clk) disable iff (!arst_n)
		x_ctl[NX].vld |-> y_ctl[NX].vld)
		else $error("offset rows out of step");

	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		x_ctl[NX].vld |-> ##MX s_ctl[NSQ].vld)
		else $error("offset quotient misaligned with root");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for point_segment_distance: directed and random queries.
// Depends only on the block itself; expected results come from a predictor below.
module tb;

	localparam int CB = 16;
	localparam int LATENCY = 3 * CB + 10;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
	} query_t;

	typedef struct packed {
		logic [CB:0]          dist_val;
		logic signed [CB-1:0] nx, ny;
		logic                 inner;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [CB-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic signed [CB-1:0] point_x = '0, point_y = '0;
	logic done;
	logic [CB:0] distance;
	logic signed [CB-1:0] nearest_x, nearest_y;
	logic on_interior;

	query_t  pending_queries[$];
	answer_t expected_answers[$];
	int      error_count = 0;
	longint  cycle_count = 0;
	int      send_idle_pct = 0;
	bit      stimulus_done = 1'b0;

	point_segment_distance #(.COORD_BITS(CB)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.point_x(point_x), .point_y(point_y), .done(done), .distance(distance),
		.nearest_x(nearest_x), .nearest_y(nearest_y), .on_interior(on_interior)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Floor square root of a non-negative 64-bit value.
	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// Largest q with q*q*den <= num*num, using 128-bit products.
	function automatic longint unsigned line_distance(longint unsigned num,
			longint unsigned den);
		logic [127:0] nsq;
		logic [127:0] t;
		longint unsigned q;
		nsq = 128'(num) * 128'(num);
		q = 0;
		for (int b = CB + 1; b >= 0; b--) begin
			t = 128'(q | (64'd1 << b));
			if (t * t * 128'(den) <= nsq)
				q = q | (64'd1 << b);
		end
		return q;
	endfunction

	function automatic longint trunc_quot(longint n, longint d);
		longint m;
		m = (n < 0) ? -n : n;
		m = m / d;
		return (n < 0) ? -m : m;
	endfunction

	// Nearest point on segment AB to C and the distance to it.
	function automatic answer_t nearest_on_segment(query_t q);
		longint dx, dy, ex, ey, fx, fy, dot, len2, crs, d1, d2;
		answer_t a;
		dx = longint'(q.bx) - q.ax;
		dy = longint'(q.by) - q.ay;
		ex = longint'(q.cx) - q.ax;
		ey = longint'(q.cy) - q.ay;
		dot = ex * dx + ey * dy;
		len2 = dx * dx + dy * dy;
		if (len2 > 0 && dot >= 0 && dot <= len2) begin
			crs = ey * dx - ex * dy;
			if (crs < 0)
				crs = -crs;
			a.nx = CB'(q.ax + trunc_quot(dot * dx, len2));
			a.ny = CB'(q.ay + trunc_quot(dot * dy, len2));
			a.dist_val = (CB+1)'(line_distance(crs, len2));
			a.inner = 1'b1;
		end else begin
			fx = longint'(q.cx) - q.bx;
			fy = longint'(q.cy) - q.by;
			d1 = ex * ex + ey * ey;
			d2 = fx * fx + fy * fy;
			// Ties go to the far end B.
			if (d1 < d2) begin
				a.nx = q.ax; a.ny = q.ay; a.dist_val = (CB+1)'(floor_sqrt(d1));
			end else begin
				a.nx = q.bx; a.ny = q.by; a.dist_val = (CB+1)'(floor_sqrt(d2));
			end
			a.inner = 1'b0;
		end
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
			cycle_count);
		error_count++;
	endtask

	function automatic query_t make_query(int ax, int ay, int bx, int by, int cx, int cy);
		query_t q;
		q.ax = CB'(ax); q.ay = CB'(ay); q.bx = CB'(bx);
		q.by = CB'(by); q.cx = CB'(cx); q.cy = CB'(cy);
		return q;
	endfunction

	// Random coordinate: mostly small spans to hit the interior, some full range.
	function automatic logic [CB-1:0] rand_coord(int span);
		if (span == 0)
			return CB'($urandom);
		return CB'($urandom_range(0, 2 * span) - span);
	endfunction

	// Driver: present the head of the queue; hold start while more items wait.
	always @(posedge clk) begin
		query_t q;
		if (arst_n) begin
			if (start && !busy)
				void'(pending_queries.pop_front());
			if (pending_queries.size() > (start && !busy ? 0 : 0) &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				q = pending_queries[0];
				start <= 1'b1;
				start_x <= q.ax; start_y <= q.ay; end_x <= q.bx;
				end_y <= q.by; point_x <= q.cx; point_y <= q.cy;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Record the expectation at the transfer edge.
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_answers.push_back(nearest_on_segment({start_x, start_y, end_x, end_y,
				point_x, point_y}));
	end

	// Monitor: each strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		answer_t e;
		cycle_count <= cycle_count + 1;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				e = expected_answers.pop_front();
				if (distance !== e.dist_val)
					report_mismatch("distance", distance, e.dist_val);
				if (nearest_x !== e.nx)
					report_mismatch("nearest_x", nearest_x, e.nx);
				if (nearest_y !== e.ny)
					report_mismatch("nearest_y", nearest_y, e.ny);
				if (on_interior !== e.inner)
					report_mismatch("on_interior", on_interior, e.inner);
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int span;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: degenerate segment, projections at ends, ties, extremes.
		pending_queries.push_back(make_query(100, 100, 100, 100, 300, -50));
		pending_queries.push_back(make_query(0, 0, 256, 0, 0, 512));
		pending_queries.push_back(make_query(0, 0, 256, 0, 256, -512));
		pending_queries.push_back(make_query(0, 0, 256, 0, 128, 77));
		pending_queries.push_back(make_query(0, 0, 256, 0, 128, -900));
		pending_queries.push_back(make_query(0, 0, 256, 0, -10, 3));
		pending_queries.push_back(make_query(0, 0, 256, 0, 300, 3));
		pending_queries.push_back(make_query(-32768, -32768, 32767, 32767, 32767, -32768));
		pending_queries.push_back(make_query(-32768, -32768, 32767, 32767, -32768, 32767));
		pending_queries.push_back(make_query(32767, 32767, -32768, -32768, 32767, 32767));
		pending_queries.push_back(make_query(-32768, 32767, 32767, -32768, -32768, -32768));
		pending_queries.push_back(make_query(-32768, -32768, -32768, -32768, 32767, 32767));
		pending_queries.push_back(make_query(32767, -32768, 32767, -32768, -32768, 32767));
		pending_queries.push_back(make_query(-32768, 0, 32767, 0, 0, 32767));
		pending_queries.push_back(make_query(0, -32768, 0, 32767, -32768, 5));
		pending_queries.push_back(make_query(10, 10, 20, 30, 15, 20));
		pending_queries.push_back(make_query(-1, -1, 1, 1, 1, -1));
		pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0));
		pending_queries.push_back(make_query(-1, -1, -1, -1, -1, -1));
		pending_queries.push_back(make_query(0, 0, 3, 7, -7, 3));
		wait (pending_queries.size() == 0);

		// Random phases: no idling, sender idle 65 %, none again, sender idle 18 %.
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 65 : (phase == 3) ? 18 : 0;
			for (int i = 0; i < 450; i++) begin
				span = (i % 5 == 0) ? 0 : (i % 5 == 1) ? 40 : (i % 5 == 2) ? 2000 : 300;
				pending_queries.push_back({rand_coord(span), rand_coord(span),
					rand_coord(span), rand_coord(span), rand_coord(span),
					rand_coord(span)});
			end
			wait (pending_queries.size() == 0);
		end
		stimulus_done = 1'b1;
		@(posedge clk);
		wait (expected_answers.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (error_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
